// ===== rtl/core/vcpc_pkg.sv =====
// Shared types and constants for the valve command packet checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package vcpc_pkg;

    // Packet layout and command codes.
    localparam logic [7:0] CMD_SWITCH_VALVE = 8'h10;
    localparam logic [7:0] VALVE_AIR        = 8'h01;
    localparam logic [7:0] VALVE_LOW_GAS    = 8'h02;
    localparam logic [7:0] VALVE_HIGH_GAS   = 8'h03;
    localparam logic [7:0] SEED_AT_RESET    = 8'd213;

    // Last byte must sit at position four or later for a full packet.
    localparam logic [2:0] POS_MIN_LAST     = 3'd4;
    localparam logic [2:0] POS_COMMAND      = 3'd2;
    localparam logic [2:0] POS_VALVE        = 3'd3;
    localparam logic [2:0] POS_LEVEL        = 3'd4;
    localparam logic [2:0] POS_MAX          = 3'd7;

    // Default depth of the verdict queue between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Result status codes.
    typedef enum logic [2:0] {
        STATUS_APPLIED       = 3'd0,
        STATUS_CHECKSUM_FAIL = 3'd1,
        STATUS_UNKNOWN_CMD   = 3'd2,
        STATUS_UNKNOWN_VALVE = 3'd3,
        STATUS_TOO_SHORT     = 3'd4
    } vcpc_status_t;

    // Verdict on one packet, handed from the front to the back.
    typedef struct packed {
        vcpc_status_t status;
        logic [2:0]   valve_mask;   // bit 0 air, bit 1 500 ppm, bit 2 10000 ppm
        logic         level_open;   // open the selected valve when set
        logic [7:0]   checksum;
    } vcpc_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/vcpc_front.sv =====
// Front end: accepts packet bytes, runs the checksum and classifies the packet.
// Depends on vcpc_pkg; pushes one verdict per packet into vcpc_queue.
`default_nettype none

module vcpc_front
    import vcpc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    input  wire logic        q_full,
    output logic             push,
    output vcpc_entry_t      push_entry
);

    logic [7:0] seed_reg;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic [7:0] cmd_reg;
    logic [7:0] sel_reg;
    logic [7:0] lvl_reg;
    logic [7:0] sum_cur;
    logic [7:0] sum_rot;
    logic       accept;
    logic [2:0] mask;

    // A beat is taken whenever the queue has room.
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // The seed enters at the first byte of each packet.
    assign sum_cur  = (pos_reg == '0) ? seed_reg : sum_reg;
    assign sum_rot  = {sum_cur[6:0], sum_cur[7]};

    always_comb begin
        sum_next = sum_rot + in_byte;
        pos_next = pos_reg;
        if (accept) begin
            if (in_last) begin
                pos_next = '0;
            end else if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    // Seed register, written from the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_AT_RESET;
        end else if (cfg_wr_en) begin
            seed_reg <= cfg_wr_data;
        end
    end

    // Byte position within the packet.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // Running checksum.
    always_ff @(posedge aclk) begin
        if (accept && !in_last) begin
            sum_reg <= sum_next;
        end
    end

    // Captured header bytes; they return to zero after every packet.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg <= '0;
            sel_reg <= '0;
            lvl_reg <= '0;
        end else if (accept) begin
            if (in_last) begin
                cmd_reg <= '0;
                sel_reg <= '0;
                lvl_reg <= '0;
            end else begin
                if (pos_reg == POS_COMMAND) begin
                    cmd_reg <= in_byte;
                end
                if (pos_reg == POS_VALVE) begin
                    sel_reg <= in_byte;
                end
                if (pos_reg == POS_LEVEL) begin
                    lvl_reg <= in_byte;
                end
            end
        end
    end

    // Valve selector decode.
    always_comb begin
        unique case (sel_reg)
            VALVE_AIR:      mask = 3'b001;
            VALVE_LOW_GAS:  mask = 3'b010;
            VALVE_HIGH_GAS: mask = 3'b100;
            default:        mask = 3'b000;
        endcase
    end

    // Classify the packet on its last byte; checks in priority order.
    always_comb begin
        push_entry.valve_mask = mask;
        push_entry.level_open = (lvl_reg != '0);
        push_entry.checksum   = sum_cur;
        priority if (pos_reg < POS_MIN_LAST) begin
            push_entry.status = STATUS_TOO_SHORT;
        end else if (in_byte != sum_cur) begin
            push_entry.status = STATUS_CHECKSUM_FAIL;
        end else if (cmd_reg != CMD_SWITCH_VALVE) begin
            push_entry.status = STATUS_UNKNOWN_CMD;
        end else if (mask == '0) begin
            push_entry.status = STATUS_UNKNOWN_VALVE;
        end else begin
            push_entry.status = STATUS_APPLIED;
        end
    end

    assign push = accept && in_last;

endmodule

`default_nettype wire

// ===== rtl/core/vcpc_queue.sv =====
// Short verdict queue decoupling the front end from the back end.
// Depends on vcpc_pkg for the entry type.
`default_nettype none

module vcpc_queue
    import vcpc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire vcpc_entry_t  push_entry,
    output logic              full,
    output logic              q_valid,
    input  wire logic         pop,
    output vcpc_entry_t       pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    vcpc_entry_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign q_valid   = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && q_valid;
    assign pop_entry = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/vcpc_back.sv =====
// Back end: applies packet verdicts to the valve states and holds the result beat.
// Depends on vcpc_pkg; pops verdicts from vcpc_queue.
`default_nettype none

module vcpc_back
    import vcpc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_valid,
    input  wire vcpc_entry_t  q_entry,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [15:0]       out_data
);

    logic [2:0]  valves_reg;
    logic [2:0]  valves_next;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    // Take a verdict when the output register is empty or being drained.
    assign pop = q_valid && (!out_valid_reg || out_ready);

    // Only an applied command touches the valves.
    always_comb begin
        valves_next = valves_reg;
        if (q_entry.status == STATUS_APPLIED) begin
            if (q_entry.level_open) begin
                valves_next = valves_reg | q_entry.valve_mask;
            end else begin
                valves_next = valves_reg & ~q_entry.valve_mask;
            end
        end
    end

    // Valve states and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valves_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                valves_reg    <= valves_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= {2'b00, q_entry.checksum, valves_next[2], valves_next[1],
                             valves_next[0], q_entry.status};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/valve_command_packet_checker.sv =====
// Valve command packet checker: top level joining front end, queue and back end.
// Depends on vcpc_pkg, vcpc_front, vcpc_queue and vcpc_back.
//
// Packet bytes stream in on the slave side, one per beat, with s_tlast on the
// checksum byte. The block takes one byte every clock cycle as long as its
// verdict queue has room; each byte needs a rotate, an add and a capture in the
// front end only. Every packet yields one result beat on the master side: its
// verdict is written into the verdict queue and then into the back end's output
// register, where the valve states are updated. The queue holds QUEUE_DEPTH
// verdicts behind the output register, so the input stalls only after
// QUEUE_DEPTH + 1 results are held back by m_tready. The checksum seed is
// written through cfg_wr_en/cfg_wr_data and takes effect at the first byte of
// the next packet.
`default_nettype none

module valve_command_packet_checker
    import vcpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,   // checksum_seed
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] data_byte
    input  wire logic        s_tlast,       // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata        // [2:0] status, [3] air_valve_open,
                                            // [4] low_gas_valve_open,
                                            // [5] high_gas_valve_open,
                                            // [13:6] computed_checksum, [15:14] zero
);

    logic        push;
    vcpc_entry_t push_entry;
    logic        q_full;
    logic        q_valid;
    logic        pop;
    vcpc_entry_t pop_entry;

    vcpc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    vcpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .pop        (pop),
        .pop_entry  (pop_entry)
    );

    vcpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_entry   (pop_entry),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for valve_command_packet_checker.
// Depends on vcpc_pkg and the RTL of the block; drives byte packets in and
// checks every verdict beat against a predictor of checksum and valve state.
`timescale 1ns / 1ps

module testbench;
    import vcpc_pkg::*;

    localparam int RANDOM_BYTES       = 850;
    localparam int DRAIN_CYCLES       = 4;
    localparam int WATCHDOG_LIMIT     = 5000;
    localparam int HOLD_AFTER_RESULTS = 40;
    localparam int HOLD_CYCLES        = 400;
    localparam int SEED_EVERY_PACKETS = 25;

    // One expected verdict beat, unpacked into its fields.
    typedef struct packed {
        vcpc_status_t status;
        logic         air_open;
        logic         low_gas_open;
        logic         high_gas_open;
        logic [7:0]   checksum;
    } valve_verdict_t;

    typedef logic [7:0] packet_bytes_t[$];

    // One step of the running checksum: rotate left by one, then add.
    function automatic logic [7:0] rotate_add(logic [7:0] sum, logic [7:0] data);
        return {sum[6:0], sum[7]} + data;
    endfunction

    // Scoreboard: tracks packet progress and valve state, queues verdicts.
    class valve_verdict_scoreboard;
        logic [7:0]     seed;
        logic [7:0]     running_sum;
        logic [2:0]     position;
        logic [7:0]     command;
        logic [7:0]     selector;
        logic [7:0]     level;
        logic [2:0]     valves;
        valve_verdict_t expected_verdicts[$];
        int             error_count;

        function new();
            seed        = SEED_AT_RESET;
            running_sum = SEED_AT_RESET;
            position    = '0;
            command     = '0;
            selector    = '0;
            level       = '0;
            valves      = '0;
            error_count = 0;
        endfunction

        function void load_seed(logic [7:0] value);
            seed = value;
        endfunction

        function int pending_count();
            return expected_verdicts.size();
        endfunction

        // Note one accepted byte; the last byte of a packet yields a verdict.
        function void predict_packet_byte(logic [7:0] data, logic last);
            logic [7:0]     sum;
            logic [2:0]     mask;
            valve_verdict_t verdict;
            // The seed is picked up only at the first byte of a packet.
            sum = (position == '0) ? seed : running_sum;
            if (!last) begin
                running_sum = rotate_add(sum, data);
                if (position == POS_COMMAND) begin
                    command = data;
                end else if (position == POS_VALVE) begin
                    selector = data;
                end else if (position == POS_LEVEL) begin
                    level = data;
                end
                if (position < POS_MAX) begin
                    position = position + 3'd1;
                end
                return;
            end
            // Valve bits: air in bit 0, 500 ppm in bit 1, 10000 ppm in bit 2.
            if (selector == VALVE_AIR) begin
                mask = 3'b001;
            end else if (selector == VALVE_LOW_GAS) begin
                mask = 3'b010;
            end else if (selector == VALVE_HIGH_GAS) begin
                mask = 3'b100;
            end else begin
                mask = 3'b000;
            end
            if (position < POS_MIN_LAST) begin
                verdict.status = STATUS_TOO_SHORT;
            end else if (data != sum) begin
                verdict.status = STATUS_CHECKSUM_FAIL;
            end else if (command != CMD_SWITCH_VALVE) begin
                verdict.status = STATUS_UNKNOWN_CMD;
            end else if (mask == 3'b000) begin
                verdict.status = STATUS_UNKNOWN_VALVE;
            end else begin
                valves = (level != 8'd0) ? (valves | mask) : (valves & ~mask);
                verdict.status = STATUS_APPLIED;
            end
            verdict.air_open      = valves[0];
            verdict.low_gas_open  = valves[1];
            verdict.high_gas_open = valves[2];
            verdict.checksum      = sum;
            expected_verdicts.push_back(verdict);
            // Packet state returns to its reset values; valves are kept.
            position    = '0;
            running_sum = seed;
            command     = '0;
            selector    = '0;
            level       = '0;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                error_count++;
            end
        endfunction

        // Check one result beat against the oldest outstanding verdict.
        function void check_verdict(logic [15:0] beat);
            valve_verdict_t want;
            if (expected_verdicts.size() == 0) begin
                $error("result beat 0x%h with no packet outstanding", beat);
                error_count++;
                return;
            end
            want = expected_verdicts.pop_front();
            compare_field("status", 32'(want.status), 32'(beat[2:0]));
            compare_field("air_valve_open", 32'(want.air_open), 32'(beat[3]));
            compare_field("low_gas_valve_open", 32'(want.low_gas_open), 32'(beat[4]));
            compare_field("high_gas_valve_open", 32'(want.high_gas_open), 32'(beat[5]));
            compare_field("computed_checksum", 32'(want.checksum), 32'(beat[13:6]));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;       // [7:0] data_byte
    logic        s_tlast;       // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;       // [2:0] status, [3] air, [4] 500 ppm, [5] 10000 ppm,
                                // [13:6] computed_checksum

    valve_verdict_scoreboard sb;
    int                      send_idle_pct;
    int                      recv_idle_pct;
    int                      results_seen;
    logic [7:0]              cur_seed;

    valve_command_packet_checker u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // 20 ns clock.
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Beat monitor and watchdog: sample both channels at the rising edge.
    always @(posedge aclk) begin : beat_monitor
        int idle_cycles;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.predict_packet_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                sb.check_verdict(m_tdata);
                results_seen <= results_seen + 1;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    // Receiver: random back-pressure, plus one long hold while bytes keep coming.
    initial begin : ready_driver
        logic next_ready;
        int   hold_left;
        bit   hold_done;
        m_tready  = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && s_tvalid && results_seen >= HOLD_AFTER_RESULTS) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                next_ready = ($urandom_range(99) >= recv_idle_pct);
            end
            @(negedge aclk);
            m_tready <= next_ready;
        end
    end

    // Offer one byte after a random gap and wait until it is taken.
    task automatic send_byte(logic [7:0] data, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do begin
            @(posedge aclk);
        end while (!(s_tvalid && s_tready));
        @(negedge aclk);
    endtask

    task automatic send_packet(packet_bytes_t pkt);
        foreach (pkt[i]) begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
    endtask

    // Build a packet of len bytes, checksum byte included.
    function automatic packet_bytes_t make_packet(logic [7:0] seed, int len,
                                                  logic [7:0] cmd, logic [7:0] sel,
                                                  logic [7:0] level, bit corrupt);
        packet_bytes_t pkt;
        logic [7:0]    sum;
        logic [7:0]    data;
        sum = seed;
        for (int i = 0; i < len - 1; i++) begin
            if (i == POS_COMMAND) begin
                data = cmd;
            end else if (i == POS_VALVE) begin
                data = sel;
            end else if (i == POS_LEVEL) begin
                data = level;
            end else begin
                data = 8'($urandom_range(255));
            end
            pkt.push_back(data);
            sum = rotate_add(sum, data);
        end
        if (corrupt) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        pkt.push_back(sum);
        return pkt;
    endfunction

    // Stop offering and wait until every verdict is back and the block is quiet.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (sb.pending_count() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_checksum_seed(logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.load_seed(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_seed = value;
    endtask

    // Stimulus: directed packets, then random packets over three idling phases.
    initial begin : stimulus
        packet_bytes_t pkt;
        int            random_bytes;
        int            packet_count;
        int            kind;
        int            len;
        logic [7:0]    cmd;
        logic [7:0]    sel;
        logic [7:0]    level;
        bit            corrupt;

        sb            = new();
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 61;
        results_seen  = 0;
        cur_seed      = SEED_AT_RESET;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A lone checksum byte is too short.
        send_packet(make_packet(cur_seed, 1, '0, '0, '0, 1'b0));
        // Open the 10000 ppm valve with a full packet.
        send_packet(make_packet(cur_seed, 6, CMD_SWITCH_VALVE, VALVE_HIGH_GAS, 8'hFF, 1'b0));
        // Unknown command, then unknown valve.
        send_packet(make_packet(cur_seed, 5, 8'hFF, VALVE_AIR, '0, 1'b0));
        send_packet(make_packet(cur_seed, 5, CMD_SWITCH_VALVE, 8'h00, '0, 1'b0));

        // Seed write in mid packet only counts from the next packet on.
        pkt = make_packet(cur_seed, 6, CMD_SWITCH_VALVE, VALVE_AIR, 8'h01, 1'b0);
        send_byte(pkt[0], 1'b0);
        send_byte(pkt[1], 1'b0);
        wait_until_idle();
        write_checksum_seed(8'h00);
        for (int i = 2; i < pkt.size(); i++) begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
        send_packet(make_packet(cur_seed, 5, 8'h00, 8'h00, 8'h00, 1'b1));
        wait_until_idle();
        write_checksum_seed(8'hFF);

        // Random packets: mostly well formed, with broken ones mixed in.
        random_bytes = 0;
        packet_count = 0;
        while (random_bytes < RANDOM_BYTES) begin
            if (random_bytes < RANDOM_BYTES / 3) begin
                send_idle_pct = 24;
                recv_idle_pct = 61;
            end else if (random_bytes < 2 * RANDOM_BYTES / 3) begin
                send_idle_pct = 61;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (packet_count % SEED_EVERY_PACKETS == SEED_EVERY_PACKETS - 1) begin
                wait_until_idle();
                case ($urandom_range(3))
                    0:       write_checksum_seed(8'h00);
                    1:       write_checksum_seed(8'hFF);
                    default: write_checksum_seed(8'($urandom_range(255)));
                endcase
            end

            kind    = $urandom_range(99);
            len     = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(5, 8);
            cmd     = CMD_SWITCH_VALVE;
            sel     = 8'($urandom_range(1, 3));
            level   = $urandom_range(1) ? 8'h00 : 8'($urandom_range(1, 255));
            corrupt = 1'b0;
            if (kind < 8) begin
                corrupt = 1'b1;
            end else if (kind < 14) begin
                do cmd = 8'($urandom_range(255)); while (cmd == CMD_SWITCH_VALVE);
            end else if (kind < 20) begin
                do sel = 8'($urandom_range(255));
                while (sel >= VALVE_AIR && sel <= VALVE_HIGH_GAS);
            end else if (kind < 26) begin
                len = $urandom_range(1, 4);
            end else if (kind < 30) begin
                // Pure noise in every captured byte.
                cmd     = 8'($urandom_range(255));
                sel     = 8'($urandom_range(255));
                level   = 8'($urandom_range(255));
                corrupt = 1'($urandom_range(1));
            end
            pkt = make_packet(cur_seed, len, cmd, sel, level, corrupt);
            send_packet(pkt);
            random_bytes += pkt.size();
            packet_count++;
        end

        wait_until_idle();
        if (sb.error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/vcpc_pkg.sv
rtl/core/vcpc_front.sv
rtl/core/vcpc_queue.sv
rtl/core/vcpc_back.sv
rtl/core/valve_command_packet_checker.sv
tb/testbench.sv
